// File: hdl/gtm_pkg.sv
// ============================================================================
// gtm_pkg
// Shared constants, register codes and width helpers for the global tone
// mapping pixel unit.
// ============================================================================
package gtm_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LUMINANCE_SCALE       = 8'd0,
        CFG_INVERSE_WHITE_SQUARED = 8'd1
    } cfg_index_t;

    // Luminance weights, Q0.16, summing to exactly one
    localparam int WEIGHT_W = 16;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RED   = 16'd17695;
    localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN = 16'd43909;
    localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE  = 16'd3932;

    // Intermediate values saturate at this many bits
    localparam int SAT_LIMIT_W = 64;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int min_int(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    // Scaled luminance L = round(k * Lw)
    function automatic int calc_lum_w(input int cb, input int f);
        return max_int(CFG_DATA_W + cb, f) + 1 - f;
    endfunction

    // round(L * iw)
    function automatic int calc_rli_w(input int cb, input int f);
        return max_int(calc_lum_w(cb, f) + CFG_DATA_W, f) + 1 - f;
    endfunction

    // Numerator 1 + round(L * iw)
    function automatic int calc_num_w(input int cb, input int f);
        return max_int(calc_rli_w(cb, f), f + 1) + 1;
    endfunction

    // Denominator 1 + L
    function automatic int calc_den_w(input int cb, input int f);
        return max_int(calc_lum_w(cb, f), f + 1) + 1;
    endfunction

    // k * num + den / 2 before saturation
    function automatic int calc_draw_w(input int cb, input int f);
        return max_int(CFG_DATA_W + calc_num_w(cb, f), calc_den_w(cb, f)) + 1;
    endfunction

    // Dividend after saturation
    function automatic int calc_dvd_w(input int cb, input int f);
        return min_int(calc_draw_w(cb, f), SAT_LIMIT_W);
    endfunction

    // Quotient bits: the divisor is at least one, so the top f bits are zero
    function automatic int calc_quo_w(input int cb, input int f);
        return calc_dvd_w(cb, f) - f;
    endfunction

endpackage

// File: hdl/global_tone_map_pixel_unit.sv
// ============================================================================
// global_tone_map_pixel_unit
// Global tone mapping of one HDR pixel per clock while not stalled:
// luminance, scaled luminance, tone factor k*(1 + L*iw)/(1 + L) through a
// row of division cells, then per-channel scaling with saturation.
// ============================================================================
//
//  channel  handshake             payload
//  -------  --------------------  ---------------------------------------
//  in       in_valid / in_stall   red_in, green_in, blue_in
//  out      out_valid / out_stall red_out, green_out, blue_out, clipped
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  One pixel per clock sustained while the output is not stalled; the
//  division row gives one quotient bit per cell.
//  Reset clears all valids and loads scale 0.18 and inverse white 1.0.
//  A stalled output parks one extra result in a skid register; only once
//  that is full does in_stall rise and the whole pipeline hold.
//  cfg_ready is always high.
//
module global_tone_map_pixel_unit
    import gtm_pkg::*;
#(
    parameter int CHANNEL_BITS  = 16,
    parameter int FRACTION_BITS = 12
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // pixel input
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [CHANNEL_BITS-1:0] red_in,
    input  logic [CHANNEL_BITS-1:0] green_in,
    input  logic [CHANNEL_BITS-1:0] blue_in,
    // pixel output
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [CHANNEL_BITS-1:0] red_out,
    output logic [CHANNEL_BITS-1:0] green_out,
    output logic [CHANNEL_BITS-1:0] blue_out,
    output logic                    clipped,
    // configuration writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int F      = FRACTION_BITS;
    localparam int DVD_W  = calc_dvd_w(CHANNEL_BITS, FRACTION_BITS);
    localparam int DEN_W  = calc_den_w(CHANNEL_BITS, FRACTION_BITS);
    localparam int QUO_W  = calc_quo_w(CHANNEL_BITS, FRACTION_BITS);
    localparam int SIDE_W = 3 * CHANNEL_BITS;

    localparam longint unsigned CFG_MAX    = (64'd1 << CFG_DATA_W) - 64'd1;
    localparam longint unsigned SCALE_RAW  = ((64'd18 << F) + 64'd50) / 64'd100;
    localparam longint unsigned INVW_RAW   = 64'd1 << F;
    localparam logic [CFG_DATA_W-1:0] SCALE_RESET =
        CFG_DATA_W'((SCALE_RAW > CFG_MAX) ? CFG_MAX : SCALE_RAW);
    localparam logic [CFG_DATA_W-1:0] INVW_RESET =
        CFG_DATA_W'((INVW_RAW > CFG_MAX) ? CFG_MAX : INVW_RAW);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] scale_reg, scale_next;
    logic [CFG_DATA_W-1:0] invw_reg, invw_next;

    assign cfg_ready = 1'b1;

    // unused indexes leave both registers alone
    always_comb
    begin
        scale_next = scale_reg;
        invw_next  = invw_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LUMINANCE_SCALE:
                begin
                    scale_next = cfg_data;
                end
                CFG_INVERSE_WHITE_SQUARED:
                begin
                    invw_next = cfg_data;
                end
                default:
                begin
                    scale_next = scale_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
            invw_reg  <= INVW_RESET;
        end
        else
        begin
            scale_reg <= scale_next;
            invw_reg  <= invw_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: everything moves unless the skid entry is full
    // ------------------------------------------------------------------
    logic skid_full_reg, skid_full_next;
    logic pipe_en;

    assign pipe_en  = !skid_full_reg;
    assign in_stall = skid_full_reg;

    // ------------------------------------------------------------------
    // Front end
    // ------------------------------------------------------------------
    logic              front_valid;
    logic [DVD_W-1:0]  front_dvd;
    logic [DEN_W-1:0]  front_den;
    logic [SIDE_W-1:0] front_side;

    gtm_front #(
        .CHANNEL_BITS  (CHANNEL_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (in_valid),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .scale     (scale_reg),
        .inv_white (invw_reg),
        .valid     (front_valid),
        .dvd       (front_dvd),
        .den       (front_den),
        .side      (front_side)
    );

    // ------------------------------------------------------------------
    // Division row: the top F dividend bits seed the remainder
    // ------------------------------------------------------------------
    logic [QUO_W:0]    cell_valid;
    logic [DEN_W-1:0]  cell_rem  [0:QUO_W];
    logic [QUO_W-1:0]  cell_quo  [0:QUO_W];
    logic [DEN_W-1:0]  cell_den  [0:QUO_W];
    logic [SIDE_W-1:0] cell_side [0:QUO_W];

    assign cell_valid[0] = front_valid;
    assign cell_rem[0]   = DEN_W'(front_dvd[DVD_W-1:QUO_W]);
    assign cell_quo[0]   = front_dvd[QUO_W-1:0];
    assign cell_den[0]   = front_den;
    assign cell_side[0]  = front_side;

    for (genvar i = 0; i < QUO_W; i++) begin : g_cell
        gtm_div_cell #(
            .DEN_W  (DEN_W),
            .QUO_W  (QUO_W),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_en),
            .valid_in  (cell_valid[i]),
            .rem_in    (cell_rem[i]),
            .quo_in    (cell_quo[i]),
            .den_in    (cell_den[i]),
            .side_in   (cell_side[i]),
            .valid_out (cell_valid[i+1]),
            .rem_out   (cell_rem[i+1]),
            .quo_out   (cell_quo[i+1]),
            .den_out   (cell_den[i+1]),
            .side_out  (cell_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Channel scaling
    // ------------------------------------------------------------------
    logic                         back_valid;
    logic [2:0][CHANNEL_BITS-1:0] back_chan;
    logic                         back_clip;

    gtm_chan_scale #(
        .CHANNEL_BITS  (CHANNEL_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .valid_in  (cell_valid[QUO_W]),
        .factor    (cell_quo[QUO_W]),
        .side_in   (cell_side[QUO_W]),
        .valid_out (back_valid),
        .chan_out  (back_chan),
        .clip_out  (back_clip)
    );

    // ------------------------------------------------------------------
    // Output register with one skid entry
    // ------------------------------------------------------------------
    logic                         out_valid_reg, out_valid_next;
    logic [2:0][CHANNEL_BITS-1:0] out_chan_reg, skid_chan_reg;
    logic                         out_clip_reg, skid_clip_reg;
    logic                         out_free;
    logic                         load_from_skid, load_from_back, load_skid;

    assign out_free       = !out_valid_reg || !out_stall;
    assign load_from_skid = out_free && skid_full_reg;
    assign load_from_back = out_free && !skid_full_reg && back_valid;
    assign load_skid      = !out_free && pipe_en && back_valid;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        skid_full_next = skid_full_reg;
        if (out_free)
        begin
            out_valid_next = skid_full_reg || back_valid;
            skid_full_next = 1'b0;
        end
        else if (load_skid)
        begin
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_from_skid)
        begin
            out_chan_reg <= skid_chan_reg;
            out_clip_reg <= skid_clip_reg;
        end
        else if (load_from_back)
        begin
            out_chan_reg <= back_chan;
            out_clip_reg <= back_clip;
        end
        if (load_skid)
        begin
            skid_chan_reg <= back_chan;
            skid_clip_reg <= back_clip;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = out_chan_reg[0];
    assign green_out = out_chan_reg[1];
    assign blue_out  = out_chan_reg[2];
    assign clipped   = out_clip_reg;

`ifndef ASSERT_OFF
    // A parked result always sits behind a valid output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid entry full while output register empty");

    // A result arriving at a stalled output must be parked, not dropped
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && back_valid && pipe_en) |=> skid_full_reg)
        else $error("result arriving at stalled output was not parked");

    // While held, the last pipeline stage keeps its result
    a_hold_back: assert property (@(posedge clk) disable iff (!rst_n)
        (!pipe_en && back_valid) |=> (back_valid && $stable(back_chan)))
        else $error("last stage changed while pipeline held");

    // The clip flag only accompanies a saturated channel
    a_clip_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_clip_reg) |->
            (red_out == {CHANNEL_BITS{1'b1}} || green_out == {CHANNEL_BITS{1'b1}}
             || blue_out == {CHANNEL_BITS{1'b1}}))
        else $error("clip flag set without a saturated channel");
`endif

endmodule

// File: hdl/gtm_front.sv
// ============================================================================
// gtm_front
// Four-stage front end: world luminance, scaled luminance, numerator and
// denominator of the tone curve, then the rounded dividend k*num + den/2.
// ============================================================================
module gtm_front
    import gtm_pkg::*;
#(
    parameter int CHANNEL_BITS  = 16,
    parameter int FRACTION_BITS = 12,
    localparam int DVD_W  = calc_dvd_w(CHANNEL_BITS, FRACTION_BITS),
    localparam int DEN_W  = calc_den_w(CHANNEL_BITS, FRACTION_BITS),
    localparam int SIDE_W = 3 * CHANNEL_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [CHANNEL_BITS-1:0] red_in,
    input  logic [CHANNEL_BITS-1:0] green_in,
    input  logic [CHANNEL_BITS-1:0] blue_in,
    input  logic [CFG_DATA_W-1:0]   scale,
    input  logic [CFG_DATA_W-1:0]   inv_white,
    output logic                    valid,
    output logic [DVD_W-1:0]        dvd,
    output logic [DEN_W-1:0]        den,
    output logic [SIDE_W-1:0]       side
);

    localparam int F         = FRACTION_BITS;
    localparam int SUM_W     = CHANNEL_BITS + WEIGHT_W + 1;
    localparam int KL_W      = CFG_DATA_W + CHANNEL_BITS;
    localparam int LUM_W     = calc_lum_w(CHANNEL_BITS, FRACTION_BITS);
    localparam int LUM_SUM_W = F + LUM_W;
    localparam int LI_W      = LUM_W + CFG_DATA_W;
    localparam int RLI_W     = calc_rli_w(CHANNEL_BITS, FRACTION_BITS);
    localparam int RLI_SUM_W = F + RLI_W;
    localparam int NUM_W     = calc_num_w(CHANNEL_BITS, FRACTION_BITS);
    localparam int KN_W      = CFG_DATA_W + NUM_W;
    localparam int DRAW_W    = calc_draw_w(CHANNEL_BITS, FRACTION_BITS);

    localparam logic [SUM_W-1:0]     LW_HALF  = SUM_W'(1) << (WEIGHT_W - 1);
    localparam logic [LUM_SUM_W-1:0] LUM_HALF = LUM_SUM_W'(1) << (F - 1);
    localparam logic [RLI_SUM_W-1:0] RLI_HALF = RLI_SUM_W'(1) << (F - 1);
    localparam logic [NUM_W-1:0]     NUM_ONE  = NUM_W'(1) << F;
    localparam logic [DEN_W-1:0]     DEN_ONE  = DEN_W'(1) << F;

    logic                    s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [SIDE_W-1:0]       s1_side_reg, s2_side_reg, s3_side_reg, s4_side_reg;
    logic [CHANNEL_BITS-1:0] s1_lw_reg;
    logic [LUM_W-1:0]        s2_lum_reg;
    logic [NUM_W-1:0]        s3_num_reg;
    logic [DEN_W-1:0]        s3_den_reg, s4_den_reg;
    logic [DVD_W-1:0]        s4_dvd_reg;

    logic [SUM_W-1:0]        lw_sum;
    logic [CHANNEL_BITS-1:0] lw_next;
    logic [KL_W-1:0]         kl_prod;
    logic [LUM_SUM_W-1:0]    lum_sum;
    logic [LUM_W-1:0]        lum_next;
    logic [LI_W-1:0]         li_prod;
    logic [RLI_SUM_W-1:0]    rli_sum;
    logic [RLI_W-1:0]        rli;
    logic [NUM_W-1:0]        num_next;
    logic [DEN_W-1:0]        den_next;
    logic [KN_W-1:0]         kn_prod;
    logic [DRAW_W-1:0]       dvd_raw;
    logic [DVD_W-1:0]        dvd_next;

    // Stage 1: weighted channel sum, rounded to Q.F
    assign lw_sum = SUM_W'(red_in)   * SUM_W'(WEIGHT_RED)
                  + SUM_W'(green_in) * SUM_W'(WEIGHT_GREEN)
                  + SUM_W'(blue_in)  * SUM_W'(WEIGHT_BLUE)
                  + LW_HALF;
    assign lw_next = lw_sum[WEIGHT_W +: CHANNEL_BITS];

    // Stage 2: L = round(k * Lw)
    assign kl_prod  = KL_W'(scale) * KL_W'(s1_lw_reg);
    assign lum_sum  = LUM_SUM_W'(kl_prod) + LUM_HALF;
    assign lum_next = lum_sum[F +: LUM_W];

    // Stage 3: num = 1 + round(L * iw), den = 1 + L
    assign li_prod  = LI_W'(s2_lum_reg) * LI_W'(inv_white);
    assign rli_sum  = RLI_SUM_W'(li_prod) + RLI_HALF;
    assign rli      = rli_sum[F +: RLI_W];
    assign num_next = NUM_W'(rli) + NUM_ONE;
    assign den_next = DEN_W'(s2_lum_reg) + DEN_ONE;

    // Stage 4: dividend k*num + den/2, saturated
    assign kn_prod = KN_W'(scale) * KN_W'(s3_num_reg);
    assign dvd_raw = DRAW_W'(kn_prod) + DRAW_W'(s3_den_reg >> 1);

    generate
        if (DRAW_W > DVD_W) begin : g_dvd_sat
            assign dvd_next = (|dvd_raw[DRAW_W-1:DVD_W]) ? {DVD_W{1'b1}}
                                                         : dvd_raw[DVD_W-1:0];
        end
        else begin : g_dvd_plain
            assign dvd_next = dvd_raw[DVD_W-1:0];
        end
    endgenerate

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg <= {blue_in, green_in, red_in};
            s1_lw_reg   <= lw_next;
            s2_side_reg <= s1_side_reg;
            s2_lum_reg  <= lum_next;
            s3_side_reg <= s2_side_reg;
            s3_num_reg  <= num_next;
            s3_den_reg  <= den_next;
            s4_side_reg <= s3_side_reg;
            s4_den_reg  <= s3_den_reg;
            s4_dvd_reg  <= dvd_next;
        end
    end

    assign valid = s4_valid_reg;
    assign dvd   = s4_dvd_reg;
    assign den   = s4_den_reg;
    assign side  = s4_side_reg;

endmodule

// File: hdl/gtm_div_cell.sv
// ============================================================================
// gtm_div_cell
// One restoring-division cell: brings down the next dividend bit, subtracts
// the divisor when it fits and shifts the quotient bit in. Cells are chained,
// one quotient bit per cell.
// ============================================================================
module gtm_div_cell
    import gtm_pkg::*;
#(
    parameter int DEN_W  = 22,
    parameter int QUO_W  = 32,
    parameter int SIDE_W = 48
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_in,
    input  logic [DEN_W-1:0]  rem_in,
    input  logic [QUO_W-1:0]  quo_in,
    input  logic [DEN_W-1:0]  den_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              valid_out,
    output logic [DEN_W-1:0]  rem_out,
    output logic [QUO_W-1:0]  quo_out,
    output logic [DEN_W-1:0]  den_out,
    output logic [SIDE_W-1:0] side_out
);

    localparam int TRY_W = DEN_W + 1;

    logic              valid_reg;
    logic [DEN_W-1:0]  rem_reg, den_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [SIDE_W-1:0] side_reg;

    logic [TRY_W-1:0]  trial;
    logic [TRY_W-1:0]  trial_diff;
    logic              fits;
    logic [DEN_W-1:0]  rem_next;
    logic [QUO_W-1:0]  quo_next;

    // Trial subtraction; the remainder always stays below the divisor
    assign trial      = {rem_in, quo_in[QUO_W-1]};
    assign fits       = (trial >= TRY_W'(den_in));
    assign trial_diff = trial - TRY_W'(den_in);
    assign rem_next   = fits ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
    assign quo_next   = {quo_in[QUO_W-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            den_reg  <= den_in;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;
    assign den_out   = den_reg;
    assign side_out  = side_reg;

endmodule

// File: hdl/gtm_chan_scale.sv
// ============================================================================
// gtm_chan_scale
// Back end: multiplies each channel by the tone factor, rounds, saturates to
// the channel range and raises the clip flag.
// ============================================================================
module gtm_chan_scale
    import gtm_pkg::*;
#(
    parameter int CHANNEL_BITS  = 16,
    parameter int FRACTION_BITS = 12,
    localparam int QUO_W  = calc_quo_w(CHANNEL_BITS, FRACTION_BITS),
    localparam int SIDE_W = 3 * CHANNEL_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         valid_in,
    input  logic [QUO_W-1:0]             factor,
    input  logic [SIDE_W-1:0]            side_in,
    output logic                         valid_out,
    output logic [2:0][CHANNEL_BITS-1:0] chan_out,
    output logic                         clip_out
);

    localparam int F      = FRACTION_BITS;
    localparam int PRD_W  = CHANNEL_BITS + QUO_W + 1;
    localparam int PC_W   = min_int(PRD_W, SAT_LIMIT_W);
    localparam int SCL_W  = PC_W - F;

    localparam logic [PRD_W-1:0] PRD_HALF = PRD_W'(1) << (F - 1);

    logic                         valid_reg;
    logic [2:0][CHANNEL_BITS-1:0] chan_reg;
    logic                         clip_reg;

    logic [2:0][CHANNEL_BITS-1:0] chan_next;
    logic [2:0]                   over;

    // Per channel: round(c * f), saturated first at the intermediate limit
    for (genvar i = 0; i < 3; i++) begin : g_chan
        logic [PRD_W-1:0] prod;
        logic [PC_W-1:0]  prod_sat;
        logic [SCL_W-1:0] scaled;

        assign prod = PRD_W'(side_in[i*CHANNEL_BITS +: CHANNEL_BITS]) * PRD_W'(factor)
                    + PRD_HALF;

        if (PRD_W > PC_W) begin : g_sat
            assign prod_sat = (|prod[PRD_W-1:PC_W]) ? {PC_W{1'b1}} : prod[PC_W-1:0];
        end
        else begin : g_plain
            assign prod_sat = prod[PC_W-1:0];
        end

        assign scaled       = prod_sat[PC_W-1:F];
        assign over[i]      = |scaled[SCL_W-1:CHANNEL_BITS];
        assign chan_next[i] = over[i] ? {CHANNEL_BITS{1'b1}} : scaled[CHANNEL_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            chan_reg <= chan_next;
            clip_reg <= |over;
        end
    end

    assign valid_out = valid_reg;
    assign chan_out  = chan_reg;
    assign clip_out  = clip_reg;

endmodule

// File: tb/global_tone_map_pixel_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// global_tone_map_pixel_checker
// Watches the pixel, result and register channels of the tone mapping unit.
// It predicts each tone-mapped pixel from its own copy of the two registers,
// queues the predictions and compares every accepted result with the oldest
// one, field by field.
// ============================================================================
module global_tone_map_pixel_checker
    import gtm_pkg::*;
#(
    parameter int CH_W = 16,
    parameter int FRAC = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [CH_W-1:0]        red_in,
    input  logic [CH_W-1:0]        green_in,
    input  logic [CH_W-1:0]        blue_in,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [CH_W-1:0]        red_out,
    input  logic [CH_W-1:0]        green_out,
    input  logic [CH_W-1:0]        blue_out,
    input  logic                   clipped,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     results_waiting,
    output int                     results_checked,
    output int                     clipped_seen
);

    // Luminance weights in Q0.16, summing to one
    localparam logic [63:0] LUMA_RED   = 64'd17695;
    localparam logic [63:0] LUMA_GREEN = 64'd43909;
    localparam logic [63:0] LUMA_BLUE  = 64'd3932;
    localparam logic [63:0] LUMA_HALF  = 64'd32768;

    localparam logic [63:0] FIX_ONE  = 64'd1 << FRAC;
    localparam logic [63:0] FIX_HALF = 64'd1 << (FRAC - 1);
    localparam logic [63:0] CHAN_TOP = (64'd1 << CH_W) - 64'd1;

    // Register values after reset: 0.18 and 1.0
    localparam logic [CFG_DATA_W-1:0] SCALE_AT_RESET     = 16'd737;
    localparam logic [CFG_DATA_W-1:0] INV_WHITE_AT_RESET = 16'd4096;

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            clipped;
    } tone_result_t;

    tone_result_t            tone_q[$];
    logic [CFG_DATA_W-1:0]   scale_k;
    logic [CFG_DATA_W-1:0]   inv_white;
    int                      mismatches = 0;
    int                      checked    = 0;
    int                      clips      = 0;

    assign fail_count      = mismatches;
    assign results_checked = checked;
    assign clipped_seen    = clips;

    initial results_waiting = 0;

    // Expected tone-mapped pixel. With 16-bit channels and registers every
    // intermediate stays well below 2^64, so no saturation step is needed.
    function automatic tone_result_t predict_tone(input logic [CH_W-1:0] r,
                                                  input logic [CH_W-1:0] g,
                                                  input logic [CH_W-1:0] b,
                                                  input logic [CFG_DATA_W-1:0] k,
                                                  input logic [CFG_DATA_W-1:0] iw);
        logic [63:0]     chan [3];
        logic [63:0]     k_w, iw_w, lw, lum, num, den, factor, scaled;
        logic [CH_W-1:0] mapped [3];
        tone_result_t    res;
        chan[0] = 64'(r);
        chan[1] = 64'(g);
        chan[2] = 64'(b);
        k_w     = 64'(k);
        iw_w    = 64'(iw);
        lw      = (chan[0] * LUMA_RED + chan[1] * LUMA_GREEN + chan[2] * LUMA_BLUE
                   + LUMA_HALF) >> 16;
        lum     = (k_w * lw + FIX_HALF) >> FRAC;
        num     = FIX_ONE + ((lum * iw_w + FIX_HALF) >> FRAC);
        den     = FIX_ONE + lum;
        // zero luminance: num == den == one, factor comes out as k exactly
        factor  = (k_w * num + (den >> 1)) / den;
        res.clipped = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            scaled = (chan[i] * factor + FIX_HALF) >> FRAC;
            if (scaled > CHAN_TOP)
            begin
                scaled      = CHAN_TOP;
                res.clipped = 1'b1;
            end
            mapped[i] = scaled[CH_W-1:0];
        end
        res.red   = mapped[0];
        res.green = mapped[1];
        res.blue  = mapped[2];
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
            report_mismatch($sformatf("result %0d %s: expected %0d, got %0d",
                                      checked, name, want, got));
    endtask

    // Predict on each accepted pixel, compare on each accepted result,
    // then apply any register write for the requests that follow
    always @(posedge clk or negedge rst_n)
    begin
        tone_result_t want;
        if (!rst_n)
        begin
            scale_k   = SCALE_AT_RESET;
            inv_white = INV_WHITE_AT_RESET;
            tone_q.delete();
            results_waiting <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                tone_q.push_back(predict_tone(red_in, green_in, blue_in, scale_k, inv_white));

            if (out_valid && !out_stall)
            begin
                if (tone_q.size() == 0)
                    report_mismatch($sformatf("result with no pixel pending: %0d %0d %0d %0d",
                                              red_out, green_out, blue_out, clipped));
                else
                begin
                    want = tone_q.pop_front();
                    check_field("red",     32'(want.red),     32'(red_out));
                    check_field("green",   32'(want.green),   32'(green_out));
                    check_field("blue",    32'(want.blue),    32'(blue_out));
                    check_field("clipped", 32'(want.clipped), 32'(clipped));
                    if (clipped)
                        clips++;
                    checked++;
                end
            end

            // indexes beyond the two registers are ignored
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LUMINANCE_SCALE:       scale_k   = cfg_data;
                    CFG_INVERSE_WHITE_SQUARED: inv_white = cfg_data;
                    default: ;
                endcase
            end

            results_waiting <= tone_q.size();
        end
    end

endmodule

// File: tb/tb_global_tone_map_pixel_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_global_tone_map_pixel_unit
// Drives pixels and register writes into the global tone mapping unit: a
// directed set of edge pixels, then random phases across register settings
// from zero to full scale, with bursty input and a varying output stall.
// The checker beside the block predicts and compares; this module gives the
// verdict.
// ============================================================================
module tb_global_tone_map_pixel_unit;
    import gtm_pkg::*;

    localparam int CHANNEL_BITS  = 16;
    localparam int FRACTION_BITS = 12;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 80;
    localparam int PHASE_PIXELS  = 70;
    localparam int NUM_PHASES    = 9;

    // Indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_TOP   = 8'hFF;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [CHANNEL_BITS-1:0]  red_in;
    logic [CHANNEL_BITS-1:0]  green_in;
    logic [CHANNEL_BITS-1:0]  blue_in;
    logic                     out_valid;
    logic                     out_stall;
    logic [CHANNEL_BITS-1:0]  red_out;
    logic [CHANNEL_BITS-1:0]  green_out;
    logic [CHANNEL_BITS-1:0]  blue_out;
    logic                     clipped;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    int fail_count;
    int results_waiting;
    int results_checked;
    int clipped_seen;

    int pixels_sent   = 0;
    int burst_left    = 0;
    int settings_used = 1;
    int cycle_count   = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    global_tone_map_pixel_unit #(
        .CHANNEL_BITS  (CHANNEL_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .clipped   (clipped),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    global_tone_map_pixel_checker #(
        .CH_W (CHANNEL_BITS),
        .FRAC (FRACTION_BITS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .red_in          (red_in),
        .green_in        (green_in),
        .blue_in         (blue_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .red_out         (red_out),
        .green_out       (green_out),
        .blue_out        (blue_out),
        .clipped         (clipped),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .results_waiting (results_waiting),
        .results_checked (results_checked),
        .clipped_seen    (clipped_seen)
    );

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, results_waiting);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Output stall: modes of free flow, light, heavy and long runs
    int stall_mode = 0;
    int mode_left  = 0;
    int run_left   = 0;

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(40, 300);
        end
        else
            mode_left <= mode_left - 1;

        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 1) == 1);
            2: out_stall <= ($urandom_range(0, 7) != 0);
            default:
            begin
                if (run_left == 0)
                begin
                    out_stall <= ~out_stall;
                    run_left  <= $urandom_range(1, 24);
                end
                else
                    run_left <= run_left - 1;
            end
        endcase
    end

    // One pixel request; gaps open between bursts of random length
    task automatic send_pixel(input logic [CHANNEL_BITS-1:0] r,
                              input logic [CHANNEL_BITS-1:0] g,
                              input logic [CHANNEL_BITS-1:0] b);
        int gap;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pixels_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap        = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 120)
                                                     : $urandom_range(0, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Hold off input until every pending result has come out
    task automatic drain_pipeline;
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_waiting != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // New register setting, only once the block is idle; a write to an
    // unused index goes in too and must change nothing
    task automatic apply_setting(input logic [CFG_DATA_W-1:0] k,
                                 input logic [CFG_DATA_W-1:0] iw);
        drain_pipeline();
        write_reg(($urandom_range(0, 1) == 1) ? CFG_INDEX_SPARE : CFG_INDEX_TOP,
                  CFG_DATA_W'($urandom));
        write_reg(CFG_LUMINANCE_SCALE, k);
        write_reg(CFG_INVERSE_WHITE_SQUARED, iw);
        settings_used++;
    endtask

    // Random channel value: full range mostly, with dark, bright, zero
    // and single-bit values mixed in
    function automatic logic [CHANNEL_BITS-1:0] pick_channel();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return CHANNEL_BITS'($urandom);
        else if (roll < 70)
            return CHANNEL_BITS'($urandom_range(0, 255));
        else if (roll < 85)
            return CHANNEL_BITS'($urandom_range(65000, 65535));
        else if (roll < 95)
            return '0;
        else
            return CHANNEL_BITS'(1) << $urandom_range(0, CHANNEL_BITS - 1);
    endfunction

    // Stimulus
    initial
    begin
        logic [CFG_DATA_W-1:0] k, iw;
        int                    p;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        red_in    <= '0;
        green_in  <= '0;
        blue_in   <= '0;
        out_stall <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pixels at the reset setting
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'hFFFF, 16'h0000, 16'h0000);
        send_pixel(16'h0000, 16'hFFFF, 16'h0000);
        send_pixel(16'h0000, 16'h0000, 16'hFFFF);
        // nonzero channels whose luminance rounds to zero
        send_pixel(16'h0001, 16'h0000, 16'h0000);
        send_pixel(16'h0000, 16'h0000, 16'h0008);
        send_pixel(16'h0001, 16'h0001, 16'h0001);
        send_pixel(16'h1000, 16'h1000, 16'h1000);
        send_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
        send_pixel(16'h5555, 16'hAAAA, 16'h5555);
        send_pixel(16'h8000, 16'h7FFF, 16'h0001);
        drain_pipeline();

        // Full-scale, then zero settings on the extreme pixels; clipping shows at full scale
        apply_setting(16'hFFFF, 16'hFFFF);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'h0001, 16'h0000, 16'h0000);
        send_pixel(16'h1000, 16'h0800, 16'h0400);
        send_pixel(16'h00FF, 16'hFF00, 16'h0F0F);
        apply_setting(16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h1234, 16'h5678, 16'h9ABC);

        // Random phases across register settings
        for (p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: begin k = 16'h0000; iw = 16'h0000; end
                1: begin k = 16'hFFFF; iw = 16'hFFFF; end
                2: begin k = 16'hFFFF; iw = 16'h0000; end
                3: begin k = 16'h0000; iw = 16'hFFFF; end
                4: begin k = 16'd4096; iw = 16'd4096; end
                5: begin k = 16'd737;  iw = 16'd4096; end
                default:
                begin
                    k  = CFG_DATA_W'($urandom);
                    iw = CFG_DATA_W'($urandom);
                end
            endcase
            apply_setting(k, iw);
            repeat (PHASE_PIXELS)
                send_pixel(pick_channel(), pick_channel(), pick_channel());
        end

        drain_pipeline();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d pixels over %0d register settings with bursty input",
                 pixels_sent, settings_used);
        $display("and varying output stall; %0d results compared, %0d clipped.",
                 results_checked, clipped_seen);
        if (fail_count == 0 && results_waiting == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
